// ===== rtl/mcd_pkg.sv =====
// Shared constants, widths and helpers for the MJD to calendar date converter.
package mcd_pkg;

   // Pipeline depth: registers from the input transfer to the result register.
   localparam int NUM_STAGES = 12;

   // Field widths
   localparam int MJD_W   = 23;
   localparam int FRAC_W  = 32;
   localparam int YEAR_W  = 14;
   localparam int MONTH_W = 4;
   localparam int DOM_W   = 5;
   localparam int HOUR_W  = 5;
   localparam int MIN_W   = 6;
   localparam int SEC_W   = 22;

   // Internal widths
   localparam int JD_W = 23;   // Julian Day number and the shifted day count
   localparam int X_W  = 24;   // 4a - 7468865
   localparam int B_W  = 7;    // Gregorian century correction
   localparam int Y_W  = 27;   // 20c - 2442
   localparam int QD_W = 15;   // raw year-count quotient
   localparam int D_W  = 14;   // year count
   localparam int CE_W = 9;    // day of the March-based year
   localparam int F_W  = 5;    // March-based month count

   // Day number range kept by the saturation
   localparam logic signed [MJD_W-1:0] MJD_DAY_MIN = -23'sd678000;
   localparam logic signed [MJD_W-1:0] MJD_DAY_MAX = 23'sd2973000;

   localparam logic [JD_W-1:0] JD_OFFSET   = 23'd2400001;
   localparam logic [JD_W-1:0] GREG_START  = 23'd2299161;
   localparam logic [JD_W-1:0] C_GREG_ADD  = 23'd1525;
   localparam logic [JD_W-1:0] C_JUL_ADD   = 23'd1524;
   localparam logic [X_W:0]    X_OFFSET    = 25'd7468865;
   localparam logic [X_W-1:0]  GREG_CYCLE  = 24'd146097;
   localparam logic [Y_W-1:0]  Y_OFFSET    = 27'd2442;
   localparam logic [Y_W-1:0]  JUL_CYCLE   = 27'd7305;
   localparam logic [JD_W-1:0] FD_NUM      = 23'd10000;
   localparam logic [JD_W-1:0] FD_DEN      = 23'd306001;
   localparam logic [D_W-1:0]  YEAR_OFFSET = 14'd4715;

   // Reciprocals for the constant divisions, floor-rounded so that the
   // estimate is the true quotient or one below it.
   localparam int B_SHIFT = 24;
   localparam logic [B_W-1:0] B_RECIP = 7'((2**24) / 146097);
   localparam int D_SHIFT = 27;
   localparam logic [QD_W-1:0] D_RECIP = 15'((2**27) / 7305);
   localparam int F_SHIFT = 24;
   localparam logic [19:0] F_RECIP = 20'((64'd10000 << 24) / 64'd306001);

   // floor(306001 * f / 10000): days before month f of the March-based year.
   function automatic logic [CE_W-1:0] month_start(input logic [F_W-1:0] f);
      logic [3:0] extra;
      case (f) inside
         [5'd0:5'd1]:   extra = 4'd0;
         [5'd2:5'd3]:   extra = 4'd1;
         5'd4:          extra = 4'd2;
         [5'd5:5'd6]:   extra = 4'd3;
         [5'd7:5'd8]:   extra = 4'd4;
         5'd9:          extra = 4'd5;
         [5'd10:5'd11]: extra = 4'd6;
         [5'd12:5'd13]: extra = 4'd7;
         5'd14:         extra = 4'd8;
         [5'd15:5'd16]: extra = 4'd9;
         default:       extra = 4'd10;
      endcase
      return CE_W'(CE_W'(f) * CE_W'(30)) + CE_W'(extra);
   endfunction

endpackage

// ===== rtl/mcd_ctl.sv =====
// Valid bits and per-stage load enables for the conversion pipeline.
module mcd_ctl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [mcd_pkg::NUM_STAGES-1:0] stage_en
);
   import mcd_pkg::*;

   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;

   // A stage loads when it is empty or its content moves on; bubbles close up.
   always_comb begin
      stage_en[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || !rsp_stall;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         stage_en[k] = !valid_ff[k] || stage_en[k+1];
      end
   end

   always_comb begin
      valid_in[0] = stage_en[0] ? req_valid : valid_ff[0];
      for (int k = 1; k < NUM_STAGES; k++) begin
         valid_in[k] = stage_en[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_stall = !stage_en[0];
   assign rsp_valid = valid_ff[NUM_STAGES-1];

endmodule

// ===== rtl/mcd_date.sv =====
// Date datapath: day number to year, month and day of month.
module mcd_date (
   input  logic                                  clock,
   input  logic [mcd_pkg::NUM_STAGES-1:0]        stage_en,
   input  logic signed [mcd_pkg::MJD_W-1:0]      req_mjd_day,
   output logic [mcd_pkg::YEAR_W-1:0]            year,
   output logic [mcd_pkg::MONTH_W-1:0]           month,
   output logic [mcd_pkg::DOM_W-1:0]             day_of_month
);
   import mcd_pkg::*;

   // stage 0: saturate and move to Julian Day
   logic signed [MJD_W-1:0] mjd_sat;
   logic [JD_W-1:0] s0_a_in, s0_a_ff;

   always_comb begin
      if (req_mjd_day < MJD_DAY_MIN) begin
         mjd_sat = MJD_DAY_MIN;
      end else if (req_mjd_day > MJD_DAY_MAX) begin
         mjd_sat = MJD_DAY_MAX;
      end else begin
         mjd_sat = req_mjd_day;
      end
      s0_a_in = JD_W'(unsigned'(mjd_sat) + JD_OFFSET);
   end

   // stage 1: calendar select, century numerator
   logic            s1_greg_in, s1_greg_ff;
   logic [X_W-1:0]  s1_x_in, s1_x_ff;
   logic [JD_W-1:0] s1_a_ff;
   logic [X_W:0]    a_x4;

   always_comb begin
      a_x4       = {s0_a_ff, 2'b00};
      s1_greg_in = (s0_a_ff >= GREG_START);
      s1_x_in    = s1_greg_in ? X_W'(a_x4 - X_OFFSET) : '0;
   end

   // stage 2: century quotient estimate
   logic [X_W+B_W-1:0] b_prod;
   logic [B_W-1:0]     s2_qb_in, s2_qb_ff;
   logic [JD_W-1:0]    s2_a_ff;
   logic               s2_greg_ff;
   logic [X_W-1:0]     s2_x_ff;

   always_comb begin
      b_prod   = (X_W+B_W)'(s1_x_ff) * (X_W+B_W)'(B_RECIP);
      s2_qb_in = B_W'(b_prod >> B_SHIFT);
   end

   // stage 3: century quotient correction
   logic [X_W-1:0]  b_rem;
   logic [B_W-1:0]  s3_b_in, s3_b_ff;
   logic [JD_W-1:0] s3_a_ff;
   logic            s3_greg_ff;

   always_comb begin
      b_rem   = s2_x_ff - X_W'(X_W'(s2_qb_ff) * GREG_CYCLE);
      s3_b_in = s2_qb_ff + B_W'(b_rem >= GREG_CYCLE);
   end

   // stage 4: shifted day count c
   logic [JD_W-1:0] s4_c_in, s4_c_ff;

   always_comb begin
      if (s3_greg_ff) begin
         s4_c_in = s3_a_ff + JD_W'(s3_b_ff) - JD_W'(s3_b_ff >> 2) + C_GREG_ADD;
      end else begin
         s4_c_in = s3_a_ff + C_JUL_ADD;
      end
   end

   // stage 5: year numerator
   logic [Y_W-1:0]  s5_y_in, s5_y_ff;
   logic [JD_W-1:0] s5_c_ff;

   assign s5_y_in = Y_W'(Y_W'(s4_c_ff) * Y_W'(20)) - Y_OFFSET;

   // stage 6: year quotient estimate
   logic [Y_W+QD_W-1:0] d_prod;
   logic [QD_W-1:0]     s6_qd_in, s6_qd_ff;
   logic [Y_W-1:0]      s6_y_ff;
   logic [JD_W-1:0]     s6_c_ff;

   always_comb begin
      d_prod   = (Y_W+QD_W)'(s5_y_ff) * (Y_W+QD_W)'(D_RECIP);
      s6_qd_in = QD_W'(d_prod >> D_SHIFT);
   end

   // stage 7: year quotient correction
   logic [Y_W-1:0]  d_rem;
   logic [D_W-1:0]  s7_d_in, s7_d_ff;
   logic [JD_W-1:0] s7_c_ff;

   always_comb begin
      d_rem   = s6_y_ff - Y_W'(Y_W'(s6_qd_ff) * JUL_CYCLE);
      s7_d_in = D_W'(s6_qd_ff + QD_W'(d_rem >= JUL_CYCLE));
   end

   // stage 8: day within the March-based year
   logic [JD_W-1:0] e_days;
   logic [CE_W-1:0] s8_ce_in, s8_ce_ff;
   logic [D_W-1:0]  s8_d_ff;

   always_comb begin
      e_days   = JD_W'(JD_W'(s7_d_ff) * JD_W'(365)) + JD_W'(s7_d_ff >> 2);
      s8_ce_in = CE_W'(s7_c_ff - e_days);
   end

   // stage 9: month quotient estimate
   logic [CE_W+19:0] f_prod;
   logic [F_W-1:0]   s9_f_in, s9_f_ff;
   logic [CE_W-1:0]  s9_ce_ff;
   logic [D_W-1:0]   s9_d_ff;

   always_comb begin
      f_prod  = (CE_W+20)'(s8_ce_ff) * (CE_W+20)'(F_RECIP);
      s9_f_in = F_W'(f_prod >> F_SHIFT);
   end

   // stage 10: month quotient correction
   logic [JD_W-1:0] f_rem;
   logic [F_W-1:0]  s10_f_in, s10_f_ff;
   logic [CE_W-1:0] s10_ce_ff;
   logic [D_W-1:0]  s10_d_ff;

   always_comb begin
      f_rem    = JD_W'(JD_W'(s9_ce_ff) * FD_NUM) - JD_W'(JD_W'(s9_f_ff) * FD_DEN);
      s10_f_in = s9_f_ff + F_W'(f_rem >= FD_DEN);
   end

   // stage 11: result fields; January and February belong to the next year
   logic [YEAR_W-1:0]  year_in, year_ff;
   logic [MONTH_W-1:0] month_in, month_ff;
   logic [DOM_W-1:0]   dom_in, dom_ff;
   logic               early_month;

   always_comb begin
      early_month = (s10_f_ff >= F_W'(14));
      dom_in      = DOM_W'(s10_ce_ff - month_start(s10_f_ff));
      month_in    = early_month ? MONTH_W'(s10_f_ff - F_W'(13))
                                : MONTH_W'(s10_f_ff - F_W'(1));
      year_in     = YEAR_W'(s10_d_ff - YEAR_OFFSET - D_W'(!early_month));
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         s0_a_ff <= s0_a_in;
      end
      if (stage_en[1]) begin
         s1_a_ff    <= s0_a_ff;
         s1_greg_ff <= s1_greg_in;
         s1_x_ff    <= s1_x_in;
      end
      if (stage_en[2]) begin
         s2_a_ff    <= s1_a_ff;
         s2_greg_ff <= s1_greg_ff;
         s2_x_ff    <= s1_x_ff;
         s2_qb_ff   <= s2_qb_in;
      end
      if (stage_en[3]) begin
         s3_a_ff    <= s2_a_ff;
         s3_greg_ff <= s2_greg_ff;
         s3_b_ff    <= s3_b_in;
      end
      if (stage_en[4]) begin
         s4_c_ff <= s4_c_in;
      end
      if (stage_en[5]) begin
         s5_c_ff <= s4_c_ff;
         s5_y_ff <= s5_y_in;
      end
      if (stage_en[6]) begin
         s6_c_ff  <= s5_c_ff;
         s6_y_ff  <= s5_y_ff;
         s6_qd_ff <= s6_qd_in;
      end
      if (stage_en[7]) begin
         s7_c_ff <= s6_c_ff;
         s7_d_ff <= s7_d_in;
      end
      if (stage_en[8]) begin
         s8_d_ff  <= s7_d_ff;
         s8_ce_ff <= s8_ce_in;
      end
      if (stage_en[9]) begin
         s9_d_ff  <= s8_d_ff;
         s9_ce_ff <= s8_ce_ff;
         s9_f_ff  <= s9_f_in;
      end
      if (stage_en[10]) begin
         s10_d_ff  <= s9_d_ff;
         s10_ce_ff <= s9_ce_ff;
         s10_f_ff  <= s10_f_in;
      end
      if (stage_en[11]) begin
         year_ff  <= year_in;
         month_ff <= month_in;
         dom_ff   <= dom_in;
      end
   end

   assign year         = year_ff;
   assign month        = month_ff;
   assign day_of_month = dom_ff;

endmodule

// ===== rtl/mcd_time.sv =====
// Time datapath: day fraction to hour, minute and second, then delay to match the date.
module mcd_time (
   input  logic                             clock,
   input  logic [mcd_pkg::NUM_STAGES-1:0]   stage_en,
   input  logic [mcd_pkg::FRAC_W-1:0]       req_day_fraction,
   output logic [mcd_pkg::HOUR_W-1:0]       hour,
   output logic [mcd_pkg::MIN_W-1:0]        minute,
   output logic [mcd_pkg::SEC_W-1:0]        second
);
   import mcd_pkg::*;

   typedef struct packed {
      logic [HOUR_W-1:0] hr;
      logic [MIN_W-1:0]  mi;
      logic [SEC_W-1:0]  se;
   } tod_type;

   localparam int T1_W = FRAC_W + HOUR_W;
   localparam int T2_W = FRAC_W + MIN_W;

   logic [T1_W-1:0]   t1;
   logic [T2_W-1:0]   t2, t3;
   logic [HOUR_W-1:0] s0_hr_ff, s1_hr_ff;
   logic [FRAC_W-1:0] s0_rem_ff, s1_rem_ff;
   logic [MIN_W-1:0]  s1_mi_ff;
   tod_type           tod_in;
   tod_type           tod_ff [2:NUM_STAGES-1];

   // each step scales the remainder and keeps the integer part
   always_comb begin
      t1        = T1_W'(req_day_fraction) * T1_W'(24);
      t2        = T2_W'(s0_rem_ff) * T2_W'(60);
      t3        = T2_W'(s1_rem_ff) * T2_W'(60);
      tod_in.hr = s1_hr_ff;
      tod_in.mi = s1_mi_ff;
      tod_in.se = t3[T2_W-1:16];
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         s0_hr_ff  <= t1[T1_W-1:FRAC_W];
         s0_rem_ff <= t1[FRAC_W-1:0];
      end
      if (stage_en[1]) begin
         s1_hr_ff  <= s0_hr_ff;
         s1_mi_ff  <= t2[T2_W-1:FRAC_W];
         s1_rem_ff <= t2[FRAC_W-1:0];
      end
      if (stage_en[2]) begin
         tod_ff[2] <= tod_in;
      end
      for (int k = 3; k < NUM_STAGES; k++) begin
         if (stage_en[k]) begin
            tod_ff[k] <= tod_ff[k-1];
         end
      end
   end

   assign hour   = tod_ff[NUM_STAGES-1].hr;
   assign minute = tod_ff[NUM_STAGES-1].mi;
   assign second = tod_ff[NUM_STAGES-1].se;

endmodule

// ===== rtl/mjd_to_calendar_date.sv =====
// Top level of the Modified Julian Date to calendar date and time-of-day converter.
//
//   channel | dir | handshake           | payload
//   --------+-----+---------------------+--------------------------------------------
//   req     | in  | req_valid/req_stall | mjd_day (s23), day_fraction (u32, 2^-32 day)
//   rsp     | out | rsp_valid/rsp_stall | year, month, day_of_month, hour, minute,
//           |     |                     | second (u22, 2^-16 s)
//
// One transfer per cycle unless rsp_stall holds a full pipe; the depth is set by
// the date path (three reciprocal-multiply divisions, each estimate plus correction).
// Synchronous reset empties every stage; payload registers are not reset.
// Each stage has a valid bit; a stage loads whenever it is empty or its content
// moves on, so bubbles close up and the input keeps taking transfers while a
// result waits on rsp_stall, until the pipe is full.
//
// Date: the day number is saturated to -678000..2973000, converted to a Julian
// Day number, and split with the Julian calendar before JD 2299161 and the
// Gregorian one from then on. Time: the fraction is scaled by 24, 60 and 60,
// keeping the carry each time; every result is truncated.
module mjd_to_calendar_date (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [mcd_pkg::MJD_W-1:0]     req_mjd_day,
   input  logic [mcd_pkg::FRAC_W-1:0]           req_day_fraction,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [mcd_pkg::YEAR_W-1:0]           rsp_year,
   output logic [mcd_pkg::MONTH_W-1:0]          rsp_month,
   output logic [mcd_pkg::DOM_W-1:0]            rsp_day_of_month,
   output logic [mcd_pkg::HOUR_W-1:0]           rsp_hour,
   output logic [mcd_pkg::MIN_W-1:0]            rsp_minute,
   output logic [mcd_pkg::SEC_W-1:0]            rsp_second
);
   import mcd_pkg::*;

   // load enable for each pipeline register rank, shared by both datapaths
   logic [NUM_STAGES-1:0] stage_en;

   mcd_ctl u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stage_en  (stage_en)
   );

   mcd_date u_date (
      .clock        (clock),
      .stage_en     (stage_en),
      .req_mjd_day  (req_mjd_day),
      .year         (rsp_year),
      .month        (rsp_month),
      .day_of_month (rsp_day_of_month)
   );

   mcd_time u_time (
      .clock            (clock),
      .stage_en         (stage_en),
      .req_day_fraction (req_day_fraction),
      .hour             (rsp_hour),
      .minute           (rsp_minute),
      .second           (rsp_second)
   );

endmodule
